### rtl/core/dasg_pkg.sv
package dasg_pkg;

    localparam int RING_DEPTH = 16;
    localparam int TIME_BITS  = 32;

    localparam int RING_AW  = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int CNT_W    = $clog2(RING_DEPTH + 1);
    localparam int OP_W     = 2;
    localparam int STREAK_W = 8;
    localparam int IVL_W    = 16;
    localparam int WCNT_W   = 5;
    localparam int PADDR_W  = 5;
    localparam int PDATA_W  = 32;
    localparam int REG_W    = PADDR_W - 2;
    localparam int WCNT_MAX = (1 << WCNT_W) - 1;
    localparam int CMP_W    = CNT_W + WCNT_W;

    // event codes
    localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
    localparam logic [OP_W-1:0] OP_FRAME = 2'd1;
    localparam logic [OP_W-1:0] OP_SAVE  = 2'd2;
    localparam logic [OP_W-1:0] OP_NOP   = 2'd3;

    // register indexes
    localparam logic [REG_W-1:0] REG_STREAK = 3'd0;
    localparam logic [REG_W-1:0] REG_IDLE   = 3'd1;
    localparam logic [REG_W-1:0] REG_GAP    = 3'd2;
    localparam logic [REG_W-1:0] REG_MAXWIN = 3'd3;
    localparam logic [REG_W-1:0] REG_WINLEN = 3'd4;

    // register reset values
    localparam logic [STREAK_W-1:0] STREAK_RST = 8'd3;
    localparam logic [IVL_W-1:0]    IDLE_RST   = 16'd5;
    localparam logic [IVL_W-1:0]    GAP_RST    = 16'd10;
    localparam logic [WCNT_W-1:0]   MAXWIN_RST = 5'd6;
    localparam logic [IVL_W-1:0]    WINLEN_RST = 16'd60;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_WALK,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [STREAK_W-1:0] streak_frames;
        logic [IVL_W-1:0]    idle_interval;
        logic [IVL_W-1:0]    min_save_gap;
        logic [WCNT_W-1:0]   max_in_window;
        logic [IVL_W-1:0]    window_length;
    } t_cfg;

    typedef struct packed {
        logic                 rd_en;
        logic [RING_AW-1:0]   rd_addr;
        logic                 wr_en;
        logic [RING_AW-1:0]   wr_addr;
        logic [TIME_BITS-1:0] wr_data;
    } t_mem_req;

    typedef struct packed {
        logic                sampled;
        logic                save_request;
        logic                alert_mode;
        logic [STREAK_W-1:0] hit_streak;
        logic [STREAK_W-1:0] miss_streak;
        logic [WCNT_W-1:0]   window_count;
    } t_result;

    function automatic logic [RING_AW-1:0] ring_next(input logic [RING_AW-1:0] head);
        logic [RING_AW-1:0] nxt;
        if (head == RING_AW'(RING_DEPTH - 1)) begin
            nxt = '0;
        end else begin
            nxt = head + RING_AW'(1);
        end
        return nxt;
    endfunction

    // slot just past the newest capture
    function automatic logic [RING_AW-1:0] ring_tail(input logic [RING_AW-1:0] head,
                                                     input logic [CNT_W-1:0]   count);
        logic [CNT_W:0] sum;
        sum = (CNT_W+1)'(head) + (CNT_W+1)'(count);
        if (sum >= (CNT_W+1)'(RING_DEPTH)) begin
            sum = sum - (CNT_W+1)'(RING_DEPTH);
        end
        return sum[RING_AW-1:0];
    endfunction

    function automatic logic [WCNT_W-1:0] win_sat(input logic [CNT_W-1:0] count);
        logic [CMP_W-1:0] wide;
        wide = CMP_W'(count);
        if (wide > CMP_W'(WCNT_MAX)) begin
            wide = CMP_W'(WCNT_MAX);
        end
        return wide[WCNT_W-1:0];
    endfunction

    function automatic logic [STREAK_W-1:0] inc_sat(input logic [STREAK_W-1:0] v);
        logic [STREAK_W-1:0] r;
        if (v == '1) begin
            r = v;
        end else begin
            r = v + STREAK_W'(1);
        end
        return r;
    endfunction

    function automatic logic gate_ok(input logic [CNT_W-1:0]  count,
                                     input logic [WCNT_W-1:0] max_win,
                                     input logic [IVL_W-1:0]  gap);
        return (CMP_W'(count) < CMP_W'(max_win)) && (gap == '0);
    endfunction

endpackage

### rtl/core/dasg_ram.sv
module dasg_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### rtl/core/dasg_regs.sv
module dasg_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [dasg_pkg::PADDR_W-1:0]     paddr,
    input  logic [dasg_pkg::PDATA_W-1:0]     pwdata,
    output logic [dasg_pkg::PDATA_W-1:0]     prdata,
    output dasg_pkg::t_cfg                   o_cfg
);

    dasg_pkg::t_cfg                r_cfg;
    logic [dasg_pkg::REG_W-1:0]    reg_idx;
    logic                          wr_stb;

    assign reg_idx = paddr[dasg_pkg::PADDR_W-1:2];
    assign wr_stb  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.streak_frames <= dasg_pkg::STREAK_RST;
            r_cfg.idle_interval <= dasg_pkg::IDLE_RST;
            r_cfg.min_save_gap  <= dasg_pkg::GAP_RST;
            r_cfg.max_in_window <= dasg_pkg::MAXWIN_RST;
            r_cfg.window_length <= dasg_pkg::WINLEN_RST;
        end else if (wr_stb) begin
            case (reg_idx)
                dasg_pkg::REG_STREAK: r_cfg.streak_frames <= pwdata[dasg_pkg::STREAK_W-1:0];
                dasg_pkg::REG_IDLE:   r_cfg.idle_interval <= pwdata[dasg_pkg::IVL_W-1:0];
                dasg_pkg::REG_GAP:    r_cfg.min_save_gap  <= pwdata[dasg_pkg::IVL_W-1:0];
                dasg_pkg::REG_MAXWIN: r_cfg.max_in_window <= pwdata[dasg_pkg::WCNT_W-1:0];
                dasg_pkg::REG_WINLEN: r_cfg.window_length <= pwdata[dasg_pkg::IVL_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            dasg_pkg::REG_STREAK: prdata = dasg_pkg::PDATA_W'(r_cfg.streak_frames);
            dasg_pkg::REG_IDLE:   prdata = dasg_pkg::PDATA_W'(r_cfg.idle_interval);
            dasg_pkg::REG_GAP:    prdata = dasg_pkg::PDATA_W'(r_cfg.min_save_gap);
            dasg_pkg::REG_MAXWIN: prdata = dasg_pkg::PDATA_W'(r_cfg.max_in_window);
            dasg_pkg::REG_WINLEN: prdata = dasg_pkg::PDATA_W'(r_cfg.window_length);
            default:              prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

### rtl/core/dasg_ctrl.sv
module dasg_ctrl (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  dasg_pkg::t_cfg                    i_cfg,
    input  logic                              i_start,
    input  logic [dasg_pkg::OP_W-1:0]         i_opcode,
    input  logic                              i_hit,
    input  logic                              i_save_ok,
    output logic                              o_busy,
    output dasg_pkg::t_mem_req                o_mem,
    input  logic [dasg_pkg::TIME_BITS-1:0]    i_rd_data,
    output logic                              o_res_valid,
    output dasg_pkg::t_result                 o_res,
    input  logic                              i_res_take
);

    localparam int TB  = dasg_pkg::TIME_BITS;
    localparam int SW  = dasg_pkg::STREAK_W;
    localparam int IW  = dasg_pkg::IVL_W;
    localparam int CW  = dasg_pkg::CNT_W;
    localparam int AW  = dasg_pkg::RING_AW;

    dasg_pkg::t_state r_state, n_state;

    logic [dasg_pkg::OP_W-1:0] r_op;
    logic                      r_hit;
    logic                      r_save_ok;

    logic          r_mode,    n_mode;
    logic [SW-1:0] r_hits,    n_hits;
    logic [SW-1:0] r_misses,  n_misses;
    logic [IW-1:0] r_idle_cd, n_idle_cd;
    logic [IW-1:0] r_gap_cd,  n_gap_cd;
    logic [TB-1:0] r_now,     n_now;
    logic [AW-1:0] r_head,    n_head;
    logic [CW-1:0] r_count,   n_count;
    logic          r_sampled, n_sampled;
    logic          r_req,     n_req;
    logic          r_gate,    n_gate;

    logic          walk;
    logic [SW-1:0] hit_inc;
    logic [SW-1:0] miss_inc;
    logic [TB-1:0] age;
    logic          expired;
    logic [CW-1:0] cnt_dec;
    logic [AW-1:0] head_inc;

    assign hit_inc  = dasg_pkg::inc_sat(r_hits);
    assign miss_inc = dasg_pkg::inc_sat(r_misses);
    assign age      = r_now - i_rd_data;
    assign expired  = age > TB'(i_cfg.window_length);
    assign cnt_dec  = r_count - CW'(1);
    assign head_inc = dasg_pkg::ring_next(r_head);

    // datapath and memory control
    always_comb begin
        n_mode    = r_mode;
        n_hits    = r_hits;
        n_misses  = r_misses;
        n_idle_cd = r_idle_cd;
        n_gap_cd  = r_gap_cd;
        n_now     = r_now;
        n_head    = r_head;
        n_count   = r_count;
        n_sampled = r_sampled;
        n_req     = r_req;
        n_gate    = r_gate;
        walk      = 1'b0;
        o_mem     = '0;
        case (r_state)
            dasg_pkg::ST_EXEC: begin
                n_sampled = 1'b0;
                n_req     = 1'b0;
                n_gate    = 1'b0;
                case (r_op)
                    dasg_pkg::OP_TICK: begin
                        n_now = r_now + TB'(1);
                        if (r_idle_cd != '0) begin
                            n_idle_cd = r_idle_cd - IW'(1);
                        end
                        if (r_gap_cd != '0) begin
                            n_gap_cd = r_gap_cd - IW'(1);
                        end
                        if (r_count != '0) begin
                            walk          = 1'b1;
                            o_mem.rd_en   = 1'b1;
                            o_mem.rd_addr = r_head;
                        end
                    end
                    dasg_pkg::OP_FRAME: begin
                        if (!r_mode) begin
                            if (r_idle_cd == '0) begin
                                n_sampled = 1'b1;
                                n_idle_cd = i_cfg.idle_interval;
                                if (r_hit) begin
                                    n_mode   = 1'b1;
                                    n_hits   = '0;
                                    n_misses = '0;
                                end
                            end
                        end else begin
                            n_sampled = 1'b1;
                            if (r_hit) begin
                                n_misses = '0;
                                if (hit_inc >= i_cfg.streak_frames) begin
                                    n_hits = '0;
                                    if (r_count != '0) begin
                                        // drop stale captures before the gate check
                                        n_gate        = 1'b1;
                                        walk          = 1'b1;
                                        o_mem.rd_en   = 1'b1;
                                        o_mem.rd_addr = r_head;
                                    end else begin
                                        n_req = dasg_pkg::gate_ok(r_count,
                                                    i_cfg.max_in_window, r_gap_cd);
                                    end
                                end else begin
                                    n_hits = hit_inc;
                                end
                            end else begin
                                n_hits = '0;
                                if (miss_inc >= i_cfg.streak_frames) begin
                                    n_mode    = 1'b0;
                                    n_misses  = '0;
                                    n_idle_cd = i_cfg.idle_interval;
                                end else begin
                                    n_misses = miss_inc;
                                end
                            end
                        end
                    end
                    dasg_pkg::OP_SAVE: begin
                        if (r_save_ok) begin
                            o_mem.wr_en   = 1'b1;
                            o_mem.wr_data = r_now;
                            n_gap_cd      = i_cfg.min_save_gap;
                            if (r_count == CW'(dasg_pkg::RING_DEPTH)) begin
                                // full: overwrite the oldest
                                o_mem.wr_addr = r_head;
                                n_head        = head_inc;
                            end else begin
                                o_mem.wr_addr = dasg_pkg::ring_tail(r_head, r_count);
                                n_count       = r_count + CW'(1);
                            end
                        end
                    end
                    default: ;
                endcase
            end
            dasg_pkg::ST_WALK: begin
                if (expired) begin
                    n_head  = head_inc;
                    n_count = cnt_dec;
                    if (cnt_dec != '0) begin
                        walk          = 1'b1;
                        o_mem.rd_en   = 1'b1;
                        o_mem.rd_addr = head_inc;
                    end
                end
                if (!walk && r_gate) begin
                    n_req = dasg_pkg::gate_ok(n_count, i_cfg.max_in_window, r_gap_cd);
                end
            end
            default: ;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            dasg_pkg::ST_IDLE: begin
                if (i_start) begin
                    n_state = dasg_pkg::ST_EXEC;
                end
            end
            dasg_pkg::ST_EXEC,
            dasg_pkg::ST_WALK: begin
                n_state = walk ? dasg_pkg::ST_WALK : dasg_pkg::ST_DONE;
            end
            dasg_pkg::ST_DONE: begin
                if (i_res_take) begin
                    n_state = dasg_pkg::ST_IDLE;
                end
            end
            default: n_state = dasg_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= dasg_pkg::ST_IDLE;
            r_mode    <= 1'b0;
            r_hits    <= '0;
            r_misses  <= '0;
            r_idle_cd <= '0;
            r_gap_cd  <= '0;
            r_now     <= '0;
            r_head    <= '0;
            r_count   <= '0;
            r_sampled <= 1'b0;
            r_req     <= 1'b0;
            r_gate    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_mode    <= n_mode;
            r_hits    <= n_hits;
            r_misses  <= n_misses;
            r_idle_cd <= n_idle_cd;
            r_gap_cd  <= n_gap_cd;
            r_now     <= n_now;
            r_head    <= n_head;
            r_count   <= n_count;
            r_sampled <= n_sampled;
            r_req     <= n_req;
            r_gate    <= n_gate;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && r_state == dasg_pkg::ST_IDLE) begin
            r_op      <= i_opcode;
            r_hit     <= i_hit;
            r_save_ok <= i_save_ok;
        end
    end

    assign o_busy      = (r_state != dasg_pkg::ST_IDLE);
    assign o_res_valid = (r_state == dasg_pkg::ST_DONE);

    always_comb begin
        o_res.sampled      = r_sampled;
        o_res.save_request = r_req;
        o_res.alert_mode   = r_mode;
        o_res.hit_streak   = r_hits;
        o_res.miss_streak  = r_misses;
        o_res.window_count = dasg_pkg::win_sat(r_count);
    end

endmodule

### rtl/core/detection_alert_save_gate.sv
// sequence: an accepted item runs EXEC, then one WALK step per ring entry examined by the
//   expiry walk (ticks, and alert hit streaks that reach the gate), then DONE until taken
// one item in flight: input stalls until the result moves to the output register, and the
//   walk reads one entry per step through the single read port of the capture-time ring
// reset: synchronous active-low i_rst_n clears mode, streaks, countdowns, time and ring
//   pointers and loads register defaults; capture-time storage is not cleared
module detection_alert_save_gate (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input item channel
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [dasg_pkg::OP_W-1:0]         i_opcode,
    input  logic                              i_hit,
    input  logic                              i_save_ok,
    // result channel
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic                              o_sampled,
    output logic                              o_save_request,
    output logic                              o_alert_mode,
    output logic [dasg_pkg::STREAK_W-1:0]     o_hit_streak,
    output logic [dasg_pkg::STREAK_W-1:0]     o_miss_streak,
    output logic [dasg_pkg::WCNT_W-1:0]       o_window_count,
    // register port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [dasg_pkg::PADDR_W-1:0]      paddr,
    input  logic [dasg_pkg::PDATA_W-1:0]      pwdata,
    output logic [dasg_pkg::PDATA_W-1:0]      prdata,
    output logic                              pready
);

    dasg_pkg::t_cfg                      cfg;
    dasg_pkg::t_mem_req                  mem;
    dasg_pkg::t_result                   res;
    logic [dasg_pkg::TIME_BITS-1:0]      rd_data;
    logic                                busy;
    logic                                res_valid;
    logic                                res_take;
    logic                                in_take;

    logic                                r_out_valid;
    dasg_pkg::t_result                   r_out;

    // register access never waits
    assign pready = 1'b1;

    dasg_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .o_cfg   (cfg)
    );

    // capture-time ring, one read and one write port
    dasg_ram #(
        .DEPTH (dasg_pkg::RING_DEPTH),
        .WIDTH (dasg_pkg::TIME_BITS)
    ) u_ring (
        .i_clk     (i_clk),
        .i_rd_en   (mem.rd_en),
        .i_rd_addr (mem.rd_addr),
        .o_rd_data (rd_data),
        .i_wr_en   (mem.wr_en),
        .i_wr_addr (mem.wr_addr),
        .i_wr_data (mem.wr_data)
    );

    // one item in flight; sequencer stalls input while working
    assign o_in_stall = busy;
    assign in_take    = i_in_valid && !busy;

    dasg_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_start     (in_take),
        .i_opcode    (i_opcode),
        .i_hit       (i_hit),
        .i_save_ok   (i_save_ok),
        .o_busy      (busy),
        .o_mem       (mem),
        .i_rd_data   (rd_data),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_take  (res_take)
    );

    // output register decouples the result from the next item
    assign res_take = res_valid && (!r_out_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_take) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (res_take) begin
            r_out <= res;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_sampled      = r_out.sampled;
    assign o_save_request = r_out.save_request;
    assign o_alert_mode   = r_out.alert_mode;
    assign o_hit_streak   = r_out.hit_streak;
    assign o_miss_streak  = r_out.miss_streak;
    assign o_window_count = r_out.window_count;

endmodule

### rtl/core/dasg_checker.sv
module dasg_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              o_out_valid,
    input logic                              i_out_stall,
    input logic                              o_sampled,
    input logic                              o_save_request,
    input logic                              o_alert_mode,
    input logic [dasg_pkg::STREAK_W-1:0]     o_hit_streak,
    input logic [dasg_pkg::STREAK_W-1:0]     o_miss_streak,
    input logic [dasg_pkg::WCNT_W-1:0]       o_window_count
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_sampled)
            && $stable(o_save_request) && $stable(o_alert_mode)
            && $stable(o_hit_streak) && $stable(o_miss_streak)
            && $stable(o_window_count))
        else $error("stalled result changed");

    // a save request comes only from a sampled alert frame
    a_req_alert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_save_request |-> o_sampled && o_alert_mode)
        else $error("save request outside alert");

    // idle keeps both streaks clear, and the streaks never run together
    a_streaks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_alert_mode || (o_hit_streak == '0 && o_miss_streak == '0))
            && (o_hit_streak == '0 || o_miss_streak == '0))
        else $error("streak counters inconsistent");

    // ring occupancy bounded by its depth
    a_win_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> dasg_pkg::CMP_W'(o_window_count)
            <= dasg_pkg::CMP_W'(dasg_pkg::RING_DEPTH))
        else $error("window count beyond ring depth");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind detection_alert_save_gate dasg_checker u_dasg_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_sampled      (o_sampled),
    .o_save_request (o_save_request),
    .o_alert_mode   (o_alert_mode),
    .o_hit_streak   (o_hit_streak),
    .o_miss_streak  (o_miss_streak),
    .o_window_count (o_window_count)
);
